@@ hdl/bsc_pkg.sv @@
// Shared types and constants for the barometric sensor compensation core.
package bsc_pkg;

    localparam int CALIB_W         = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int C5_SHIFT        = 8;
    localparam int DT_W            = CALIB_W + C5_SHIFT + 1;
    localparam int PRD1_W          = 44;
    localparam int SQD_W           = 2 * DT_W;
    localparam int TEMP_W          = 20;
    localparam int OFF_W           = 40;
    localparam int SENS_W          = 40;
    localparam int T2_W            = 18;
    localparam int LO_W            = 18;
    localparam int SQ_W            = 2 * LO_W;
    localparam int CORR_W          = 39;
    localparam int TEMP_SHIFT      = 23;
    localparam int OFF_SHIFT       = 7;
    localparam int SENS_SHIFT      = 8;
    localparam int T2_SHIFT        = 31;
    localparam int OFF_BASE_SHIFT  = 16;
    localparam int SENS_BASE_SHIFT = 15;
    localparam int SENS_SPLIT      = 20;
    localparam int PROD_SHIFT      = 21;
    localparam int PRES_SHIFT      = 15;
    localparam int PRES_W          = 32;
    localparam int TOUT_W          = 19;

    localparam logic signed [TEMP_W-1:0] TEMP_REF     = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW    = -20'sd1500;
    localparam logic signed [TEMP_W-1:0] TEMP_OUT_MAX = 20'sd262143;
    localparam logic signed [TEMP_W-1:0] TEMP_OUT_MIN = -20'sd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESSURE_SENSITIVITY  = 3'd0,
        CFG_PRESSURE_OFFSET       = 3'd1,
        CFG_SENS_TEMP_COEFF       = 3'd2,
        CFG_OFFSET_TEMP_COEFF     = 3'd3,
        CFG_REFERENCE_TEMPERATURE = 3'd4,
        CFG_TEMPERATURE_SLOPE     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CALIB_W-1:0] pressure_sensitivity;
        logic [CALIB_W-1:0] pressure_offset;
        logic [CALIB_W-1:0] sens_temp_coeff;
        logic [CALIB_W-1:0] offset_temp_coeff;
        logic [CALIB_W-1:0] reference_temperature;
        logic [CALIB_W-1:0] temperature_slope;
    } t_calib;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [T2_W-1:0]          t2;
    } t_first_res;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_second_res;

endpackage

@@ hdl/bsc_first_order.sv @@
// First-order compensation pipeline: dT, temperature, offset, sensitivity and the T2 term.
module bsc_first_order
    import bsc_pkg::*;
#(
    parameter int ADC_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_calib              i_calib,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [ADC_BITS-1:0] i_d1,
    input  logic [ADC_BITS-1:0] i_d2,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ADC_BITS-1:0] o_d1,
    output t_first_res          o_res
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] r_vld;

    logic [ADC_BITS-1:0]      r_d1_s1;
    logic signed [DT_W-1:0]   r_dt;
    logic signed [DT_W-1:0]   n_dt;

    logic [ADC_BITS-1:0]      r_d1_s2;
    logic signed [PRD1_W-1:0] r_p_temp;
    logic signed [PRD1_W-1:0] r_p_off;
    logic signed [PRD1_W-1:0] r_p_sens;
    logic signed [SQD_W-1:0]  r_sq;
    logic signed [PRD1_W-1:0] n_p_temp;
    logic signed [PRD1_W-1:0] n_p_off;
    logic signed [PRD1_W-1:0] n_p_sens;
    logic signed [SQD_W-1:0]  n_sq;

    logic [ADC_BITS-1:0]      r_d1_s3;
    t_first_res               r_res;
    t_first_res               n_res;
    logic signed [PRD1_W-1:0] temp_sh;
    logic signed [PRD1_W-1:0] off_sh;
    logic signed [PRD1_W-1:0] sens_sh;

    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    assign n_dt = $signed({{(DT_W-ADC_BITS){1'b0}}, i_d2})
                - $signed({1'b0, i_calib.reference_temperature, {C5_SHIFT{1'b0}}});

    assign n_p_temp = r_dt * $signed({1'b0, i_calib.temperature_slope});
    assign n_p_off  = r_dt * $signed({1'b0, i_calib.offset_temp_coeff});
    assign n_p_sens = r_dt * $signed({1'b0, i_calib.sens_temp_coeff});
    assign n_sq     = r_dt * r_dt;

    assign temp_sh = r_p_temp >>> TEMP_SHIFT;
    assign off_sh  = r_p_off >>> OFF_SHIFT;
    assign sens_sh = r_p_sens >>> SENS_SHIFT;

    always_comb begin
        n_res.temp = TEMP_REF + $signed(temp_sh[TEMP_W-1:0]);
        n_res.off  = $signed({{(OFF_W-CALIB_W-OFF_BASE_SHIFT){1'b0}},
                              i_calib.pressure_offset, {OFF_BASE_SHIFT{1'b0}}})
                   + $signed(off_sh[OFF_W-1:0]);
        n_res.sens = $signed({{(SENS_W-CALIB_W-SENS_BASE_SHIFT){1'b0}},
                              i_calib.pressure_sensitivity, {SENS_BASE_SHIFT{1'b0}}})
                   + $signed(sens_sh[SENS_W-1:0]);
        n_res.t2   = r_sq[T2_SHIFT +: T2_W];
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d1_s1 <= i_d1;
            r_dt    <= n_dt;
        end
        if (adv[1]) begin
            r_d1_s2  <= r_d1_s1;
            r_p_temp <= n_p_temp;
            r_p_off  <= n_p_off;
            r_p_sens <= n_p_sens;
            r_sq     <= n_sq;
        end
        if (adv[2]) begin
            r_d1_s3 <= r_d1_s2;
            r_res   <= n_res;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_d1    = r_d1_s3;
    assign o_res   = r_res;

endmodule

@@ hdl/bsc_second_order.sv @@
// Second-order correction pipeline applied below the reference temperature.
module bsc_second_order
    import bsc_pkg::*;
#(
    parameter int ADC_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [ADC_BITS-1:0] i_d1,
    input  t_first_res          i_res,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ADC_BITS-1:0] o_d1,
    output t_second_res         o_res
);

    localparam int STAGES = 2;

    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] r_vld;

    logic [ADC_BITS-1:0]     r_d1_s1;
    t_first_res              r_first;
    logic signed [SQ_W-1:0]  r_lsq;
    logic signed [SQ_W-1:0]  r_vsq;
    logic                    r_low;
    logic                    r_vlow;
    logic signed [TEMP_W-1:0] lo_full;
    logic signed [TEMP_W-1:0] vlo_full;
    logic signed [LO_W-1:0]  lo;
    logic signed [LO_W-1:0]  vlo;
    logic signed [SQ_W-1:0]  n_lsq;
    logic signed [SQ_W-1:0]  n_vsq;
    logic                    n_low;
    logic                    n_vlow;

    logic [ADC_BITS-1:0]     r_d1_s2;
    t_second_res             r_res;
    t_second_res             n_res;
    logic [CORR_W-1:0]       lsq_u;
    logic [CORR_W-1:0]       vsq_u;
    logic [CORR_W-1:0]       lsq5;
    logic [CORR_W-1:0]       vsq7;
    logic [CORR_W-1:0]       vsq11;
    logic [CORR_W-1:0]       off2;
    logic [CORR_W-1:0]       sens2;

    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
        end
    end

    assign lo_full  = i_res.temp - TEMP_REF;
    assign vlo_full = i_res.temp - TEMP_VLOW;
    assign lo       = $signed(lo_full[LO_W-1:0]);
    assign vlo      = $signed(vlo_full[LO_W-1:0]);
    assign n_lsq    = lo * lo;
    assign n_vsq    = vlo * vlo;
    assign n_low    = i_res.temp < TEMP_REF;
    assign n_vlow   = i_res.temp < TEMP_VLOW;

    assign lsq_u = {{(CORR_W-SQ_W){1'b0}}, r_lsq};
    assign vsq_u = {{(CORR_W-SQ_W){1'b0}}, r_vsq};
    assign lsq5  = (lsq_u << 2) + lsq_u;
    assign vsq7  = (vsq_u << 3) - vsq_u;
    assign vsq11 = (vsq_u << 3) + (vsq_u << 1) + vsq_u;
    assign off2  = (lsq5 >> 1) + (r_vlow ? vsq7 : '0);
    assign sens2 = (lsq5 >> 2) + (r_vlow ? (vsq11 >> 1) : '0);

    always_comb begin
        n_res.temp = r_first.temp;
        n_res.off  = r_first.off;
        n_res.sens = r_first.sens;
        if (r_low) begin
            n_res.temp = r_first.temp - $signed({{(TEMP_W-T2_W){1'b0}}, r_first.t2});
            n_res.off  = r_first.off - $signed({{(OFF_W-CORR_W){1'b0}}, off2});
            n_res.sens = r_first.sens - $signed({{(SENS_W-CORR_W){1'b0}}, sens2});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d1_s1 <= i_d1;
            r_first <= i_res;
            r_lsq   <= n_lsq;
            r_vsq   <= n_vsq;
            r_low   <= n_low;
            r_vlow  <= n_vlow;
        end
        if (adv[1]) begin
            r_d1_s2 <= r_d1_s1;
            r_res   <= n_res;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_d1    = r_d1_s2;
    assign o_res   = r_res;

endmodule

@@ hdl/bsc_pressure.sv @@
// Pressure pipeline: split wide product, scaling, offset removal, temperature clamp and output register.
module bsc_pressure
    import bsc_pkg::*;
#(
    parameter int ADC_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [ADC_BITS-1:0]      i_d1,
    input  t_second_res              i_res,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [PRES_W-1:0] o_pressure,
    output logic signed [TOUT_W-1:0] o_temperature
);

    localparam int STAGES = 3;
    localparam int PL_W   = ADC_BITS + SENS_SPLIT;
    localparam int PH_W   = ADC_BITS + 1 + SENS_W - SENS_SPLIT;
    localparam int PRD_W  = PH_W + SENS_SPLIT;
    localparam int SH_W   = PRD_W - PROD_SHIFT;
    localparam int DIF_W  = ((SH_W > OFF_W) ? SH_W : OFF_W) + 1;
    localparam int PV_W   = DIF_W - PRES_SHIFT;

    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] r_vld;

    logic [PL_W-1:0]           r_p_lo;
    logic signed [PH_W-1:0]    r_p_hi;
    logic signed [OFF_W-1:0]   r_off_s1;
    logic signed [TOUT_W-1:0]  r_temp_s1;
    logic [PL_W-1:0]           n_p_lo;
    logic signed [PH_W-1:0]    n_p_hi;
    logic signed [TOUT_W-1:0]  n_temp;

    logic signed [PRD_W-1:0]   r_prod;
    logic signed [OFF_W-1:0]   r_off_s2;
    logic signed [TOUT_W-1:0]  r_temp_s2;
    logic signed [PRD_W-1:0]   n_prod;

    logic signed [PRES_W-1:0]  r_pres;
    logic signed [TOUT_W-1:0]  r_temp_s3;
    logic signed [SH_W-1:0]    sh;
    logic signed [DIF_W-1:0]   diff;
    logic signed [PRES_W-1:0]  n_pres;

    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    assign n_p_lo = i_d1 * i_res.sens[SENS_SPLIT-1:0];
    assign n_p_hi = $signed({1'b0, i_d1}) * $signed(i_res.sens[SENS_W-1:SENS_SPLIT]);

    always_comb begin
        if (i_res.temp > TEMP_OUT_MAX) begin
            n_temp = TEMP_OUT_MAX[TOUT_W-1:0];
        end else if (i_res.temp < TEMP_OUT_MIN) begin
            n_temp = TEMP_OUT_MIN[TOUT_W-1:0];
        end else begin
            n_temp = i_res.temp[TOUT_W-1:0];
        end
    end

    assign n_prod = $signed({r_p_hi, {SENS_SPLIT{1'b0}}})
                  + $signed({{(PRD_W-PL_W){1'b0}}, r_p_lo});

    // The scaled result stays well inside 32 bits, so sign extension is exact.
    assign sh     = $signed(r_prod[PRD_W-1:PROD_SHIFT]);
    assign diff   = $signed({{(DIF_W-SH_W){sh[SH_W-1]}}, sh})
                  - $signed({{(DIF_W-OFF_W){r_off_s2[OFF_W-1]}}, r_off_s2});
    assign n_pres = $signed({{(PRES_W-PV_W){diff[DIF_W-1]}}, diff[DIF_W-1:PRES_SHIFT]});

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_p_lo    <= n_p_lo;
            r_p_hi    <= n_p_hi;
            r_off_s1  <= i_res.off;
            r_temp_s1 <= n_temp;
        end
        if (adv[1]) begin
            r_prod    <= n_prod;
            r_off_s2  <= r_off_s1;
            r_temp_s2 <= r_temp_s1;
        end
        if (adv[2]) begin
            r_pres    <= n_pres;
            r_temp_s3 <= r_temp_s2;
        end
    end

    assign o_valid       = r_vld[STAGES-1];
    assign o_pressure    = r_pres;
    assign o_temperature = r_temp_s3;

endmodule

@@ hdl/baro_sensor_compensation_core.sv @@
// Top level of the barometric pressure and temperature compensation core.
//
//   Channel   Direction  Handshake               Payload
//   input     in         i_valid / o_stall       i_raw_pressure, i_raw_temperature
//   result    out        o_valid / i_stall       o_pressure, o_temperature
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Eight register stages: three for the first-order terms, two for the second-order
// correction and three for the split pressure product and the output register.
// One transaction enters per cycle while o_stall is low.
// A stall on the result side fills empty stages first; only a full pipeline stalls
// the input. Reset clears all valid bits and the calibration words to zero.
module baro_sensor_compensation_core
    import bsc_pkg::*;
#(
    parameter int ADC_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [23:0]              i_raw_pressure,
    input  logic [23:0]              i_raw_temperature,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [PRES_W-1:0] o_pressure,
    output logic signed [TOUT_W-1:0] o_temperature,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CALIB_W-1:0]       i_cfg_data
);

    t_calib r_calib;

    logic                first_valid;
    logic                first_stall;
    logic [ADC_BITS-1:0] first_d1;
    t_first_res          first_res;

    logic                second_valid;
    logic                second_stall;
    logic [ADC_BITS-1:0] second_d1;
    t_second_res         second_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRESSURE_SENSITIVITY:  r_calib.pressure_sensitivity  <= i_cfg_data;
                CFG_PRESSURE_OFFSET:       r_calib.pressure_offset       <= i_cfg_data;
                CFG_SENS_TEMP_COEFF:       r_calib.sens_temp_coeff       <= i_cfg_data;
                CFG_OFFSET_TEMP_COEFF:     r_calib.offset_temp_coeff     <= i_cfg_data;
                CFG_REFERENCE_TEMPERATURE: r_calib.reference_temperature <= i_cfg_data;
                CFG_TEMPERATURE_SLOPE:     r_calib.temperature_slope     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bsc_first_order #(
        .ADC_BITS (ADC_BITS)
    ) u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_calib (r_calib),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_d1    (i_raw_pressure[ADC_BITS-1:0]),
        .i_d2    (i_raw_temperature[ADC_BITS-1:0]),
        .o_valid (first_valid),
        .i_stall (first_stall),
        .o_d1    (first_d1),
        .o_res   (first_res)
    );

    bsc_second_order #(
        .ADC_BITS (ADC_BITS)
    ) u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (first_valid),
        .o_stall (first_stall),
        .i_d1    (first_d1),
        .i_res   (first_res),
        .o_valid (second_valid),
        .i_stall (second_stall),
        .o_d1    (second_d1),
        .o_res   (second_res)
    );

    bsc_pressure #(
        .ADC_BITS (ADC_BITS)
    ) u_pressure (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (second_valid),
        .o_stall       (second_stall),
        .i_d1          (second_d1),
        .i_res         (second_res),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pressure    (o_pressure),
        .o_temperature (o_temperature)
    );

endmodule

@@ hdl/bsc_checker.sv @@
// Port-level checker for the compensation core and its bind statement.
module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_pressure,
    input logic [18:0] o_temperature
);

    // The first result after reset needs the full pipeline depth.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n ##1 i_rst_n |-> !o_valid ##1 !o_valid ##1 !o_valid)
        else $error("result appeared too soon after reset");

    // Input backpressure only comes from a held result.
    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the result side was free");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pressure) && $stable(o_temperature))
        else $error("stalled result changed");

endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (.*);

@@ verif/tb_baro_sensor_compensation_core.sv @@
// Self-checking testbench for the barometric pressure and temperature compensation core.
module tb_baro_sensor_compensation_core;
    import bsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADC_BITS = 24;
    localparam logic [23:0] ADC_MASK = 24'((1 << ADC_BITS) - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam longint PRES_MAX = 64'sd2147483647;
    localparam longint PRES_MIN = -64'sd2147483648;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 300;

    typedef struct {
        logic signed [PRES_W-1:0] pressure;
        logic signed [TOUT_W-1:0] temperature;
    } t_comp_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [23:0]              i_raw_pressure = '0;
    logic [23:0]              i_raw_temperature = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [PRES_W-1:0] o_pressure;
    logic signed [TOUT_W-1:0] o_temperature;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CALIB_W-1:0]       i_cfg_data = '0;

    t_calib       calib_shadow = '0;
    t_comp_result pending_readings[$];
    int           mismatch_count = 0;
    bit           input_gaps_on = 1'b0;
    bit           result_stall_on = 1'b0;

    baro_sensor_compensation_core #(.ADC_BITS(ADC_BITS)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_comp_result compensate_reading(logic [23:0] raw_p, logic [23:0] raw_t);
        longint d1, d2, dt, temp, off, sens, t2, below, very_cold, off2, sens2, pres;
        longint c1, c2, c3, c4, c5, c6;
        t_comp_result res;
        d1 = {40'd0, raw_p & ADC_MASK};
        d2 = {40'd0, raw_t & ADC_MASK};
        c1 = {48'd0, calib_shadow.pressure_sensitivity};
        c2 = {48'd0, calib_shadow.pressure_offset};
        c3 = {48'd0, calib_shadow.sens_temp_coeff};
        c4 = {48'd0, calib_shadow.offset_temp_coeff};
        c5 = {48'd0, calib_shadow.reference_temperature};
        c6 = {48'd0, calib_shadow.temperature_slope};
        dt = d2 - (c5 <<< C5_SHIFT);
        temp = longint'(TEMP_REF) + ((dt * c6) >>> TEMP_SHIFT);
        off = (c2 <<< OFF_BASE_SHIFT) + ((c4 * dt) >>> OFF_SHIFT);
        sens = (c1 <<< SENS_BASE_SHIFT) + ((c3 * dt) >>> SENS_SHIFT);
        if (temp < longint'(TEMP_REF)) begin
            t2 = (dt * dt) >>> T2_SHIFT;
            below = temp - longint'(TEMP_REF);
            off2 = (5 * below * below) >>> 1;
            sens2 = (5 * below * below) >>> 2;
            if (temp < longint'(TEMP_VLOW)) begin
                very_cold = temp - longint'(TEMP_VLOW);
                off2 += 7 * very_cold * very_cold;
                sens2 += (11 * very_cold * very_cold) >>> 1;
            end
            temp -= t2;
            off -= off2;
            sens -= sens2;
        end
        pres = (((d1 * sens) >>> PROD_SHIFT) - off) >>> PRES_SHIFT;
        if (pres > PRES_MAX) pres = PRES_MAX;
        if (pres < PRES_MIN) pres = PRES_MIN;
        if (temp > longint'(TEMP_OUT_MAX)) temp = longint'(TEMP_OUT_MAX);
        if (temp < longint'(TEMP_OUT_MIN)) temp = longint'(TEMP_OUT_MIN);
        res.pressure = pres[PRES_W-1:0];
        res.temperature = temp[TOUT_W-1:0];
        return res;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [CALIB_W-1:0] random_calib_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 24) return '1;
        return CALIB_W'($urandom);
    endfunction

    function automatic logic [23:0] clip_adc(longint v);
        if (v < 0) return '0;
        if (v > longint'(ADC_MASK)) return ADC_MASK;
        return v[23:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_raw_pressure = raw_p;
        i_raw_temperature = raw_t;
        do @(posedge i_clk); while (o_stall);
        pending_readings.push_back(compensate_reading(raw_p, raw_t));
    endtask

    task automatic input_gap();
        int n;
        n = ($urandom_range(0, 99) < 55) ? 0 : gap_length();
        if (input_gaps_on && n > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_raw_pressure = 24'($urandom);
            i_raw_temperature = 24'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_calib(input logic [CFG_IDX_W-1:0] idx, input logic [CALIB_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PRESSURE_SENSITIVITY:  calib_shadow.pressure_sensitivity = value;
            CFG_PRESSURE_OFFSET:       calib_shadow.pressure_offset = value;
            CFG_SENS_TEMP_COEFF:       calib_shadow.sens_temp_coeff = value;
            CFG_OFFSET_TEMP_COEFF:     calib_shadow.offset_temp_coeff = value;
            CFG_REFERENCE_TEMPERATURE: calib_shadow.reference_temperature = value;
            CFG_TEMPERATURE_SLOPE:     calib_shadow.temperature_slope = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_index = 3'($urandom);
        i_cfg_data = CALIB_W'($urandom);
    endtask

    task automatic load_calibration(input logic [CALIB_W-1:0] c1, c2, c3, c4, c5, c6);
        drain_results();
        write_calib(CFG_PRESSURE_SENSITIVITY, c1);
        write_calib(CFG_PRESSURE_OFFSET, c2);
        write_calib(CFG_SENS_TEMP_COEFF, c3);
        write_calib(CFG_OFFSET_TEMP_COEFF, c4);
        write_calib(CFG_REFERENCE_TEMPERATURE, c5);
        write_calib(CFG_TEMPERATURE_SLOPE, c6);
    endtask

    task automatic test_reset_calibration();
        send_reading('1, '1);
        send_reading('0, '0);
        send_reading(24'h5A5A5A, 24'hA5A5A5);
    endtask

    task automatic test_nominal_and_cold();
        logic [23:0] ref_raw;
        load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        ref_raw = 24'(33464 * 256);
        send_reading(24'd9085466, 24'd8569150);
        send_reading(24'd9085466, ref_raw);
        send_reading(24'd9085466, ref_raw - 24'd1);
        send_reading(24'd9085466, ref_raw - 24'd500000);
        send_reading(24'd9085466, ref_raw - 24'd1100000);
        send_reading(24'd9085466, '0);
        send_reading('1, '1);
        send_reading('0, '0);
    endtask

    task automatic test_extreme_calibration();
        load_calibration('1, '1, '1, '1, '1, '1);
        send_reading('0, '0);
        send_reading('1, '0);
        send_reading('0, '1);
        send_reading('1, '1);
        load_calibration('1, '0, '1, '0, '0, '1);
        send_reading('1, '1);
        send_reading('1, '0);
        load_calibration('0, '1, '0, '1, '1, '0);
        send_reading('1, '0);
    endtask

    task automatic test_unmapped_index();
        drain_results();
        write_calib(CFG_IDX_SPARE_LO, '1);
        write_calib(CFG_IDX_SPARE_HI, 16'h1234);
        send_reading(24'hC0FFEE, 24'h123456);
        send_reading('1, '0);
    endtask

    task automatic test_random_readings();
        logic [23:0] raw_p, raw_t;
        longint ref_raw;
        int r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_calibration(random_calib_word(), random_calib_word(), random_calib_word(),
                             random_calib_word(), random_calib_word(), random_calib_word());
            if (phase == 2) write_calib(CFG_IDX_SPARE_HI, random_calib_word());
            input_gaps_on = (phase != 0);
            result_stall_on = (phase != 0);
            ref_raw = longint'(calib_shadow.reference_temperature) * 256;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) drain_results();
                r = $urandom_range(0, 99);
                raw_p = (r < 5) ? '0 : (r < 10) ? '1 : 24'($urandom);
                case ($urandom_range(0, 3))
                    0: raw_t = 24'($urandom);
                    1: raw_t = clip_adc(ref_raw + longint'($urandom_range(0, 1 << 16))
                                        - (longint'(1) << $urandom_range(4, 22)));
                    2: raw_t = clip_adc(ref_raw - longint'($urandom_range(0, 1 << 23)));
                    default: raw_t = ($urandom_range(0, 1) != 0) ? '1 : '0;
                endcase
                input_gap();
                send_reading(raw_p, raw_t);
            end
        end
        input_gaps_on = 1'b0;
        result_stall_on = 1'b0;
    endtask

    initial begin : result_stall_gen
        int run;
        forever begin
            if (!result_stall_on) begin
                @(negedge i_clk);
                i_stall = 1'b0;
            end else begin
                run = $urandom_range(1, 12);
                repeat (run) @(negedge i_clk) i_stall = 1'b0;
                run = gap_length();
                repeat (run) @(negedge i_clk) i_stall = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_comp_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected result p=%0d t=%0d",
                                          o_pressure, o_temperature));
            end else begin
                want = pending_readings.pop_front();
                if (o_pressure !== want.pressure)
                    report_mismatch($sformatf("pressure %0d, expected %0d",
                                              o_pressure, want.pressure));
                if (o_temperature !== want.temperature)
                    report_mismatch($sformatf("temperature %0d, expected %0d",
                                              o_temperature, want.temperature));
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_calibration();
        test_nominal_and_cold();
        test_extreme_calibration();
        test_unmapped_index();
        test_random_readings();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_baro_sensor_compensation_core passed");
        end else begin
            $display("tb_baro_sensor_compensation_core failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_baro_sensor_compensation_core failed");
        $finish;
    end

endmodule
